// ===== design/drw_pkg.sv =====
// ----------------------------------------------------------------------------
// drw_pkg: shared types and constants for the display RAM window writer
// Panel geometry, item kind codes, window and result structures.
// ----------------------------------------------------------------------------
package drw_pkg;

  // Panel geometry in pixels; the width stays a multiple of 8, at most 256.
  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 296;

  localparam int COL_W  = 5;   // byte column of the window
  localparam int ROW_W  = 9;   // row of the window and y counter
  localparam int POS_W  = 9;   // pixel x counter
  localparam int OPND_W = 9;
  localparam int DATA_W = 8;
  localparam int ADDR_W = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  // y * PANEL_WIDTH + x stays below 2^18 for any width up to 256
  localparam int SUM_W = ADDR_W + 4;
  localparam int FULL_ADDR_W = SUM_W - 3;
  localparam logic [FULL_ADDR_W-1:0] ADDR_LIMIT =
    FULL_ADDR_W'((PANEL_WIDTH * PANEL_HEIGHT) / 8);

  typedef enum logic [1:0] {
    KIND_SET_X        = 2'd0,
    KIND_SET_Y        = 2'd1,
    KIND_WRITE_BW     = 2'd2,
    KIND_WRITE_COLOUR = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_START = 2'd0,
    REG_X_END   = 2'd1,
    REG_Y_START = 2'd2,
    REG_Y_END   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] x_start_column;
    logic [COL_W-1:0] x_end_column;
    logic [ROW_W-1:0] y_start_row;
    logic [ROW_W-1:0] y_end_row;
  } window_t;

  typedef struct packed {
    kind_t             kind;
    logic [OPND_W-1:0] operand;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic              plane;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] data_byte;
    logic              out_of_range;
  } result_t;

endpackage

// ===== design/drw_addr_counter.sv =====
// ----------------------------------------------------------------------------
// drw_addr_counter: x/y address counter of the write window
// Holds the pixel x and row counters, forms the byte address of a write and
// steps the counters with window wrap when an item is processed.
// ----------------------------------------------------------------------------
module drw_addr_counter (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  drw_pkg::item_t   item,
  input  drw_pkg::window_t window,
  output drw_pkg::result_t result
);

  logic [drw_pkg::POS_W-1:0]       x_position;
  logic [drw_pkg::POS_W-1:0]       x_position_next;
  logic [drw_pkg::ROW_W-1:0]       y_position;
  logic [drw_pkg::ROW_W-1:0]       y_position_next;
  logic [drw_pkg::SUM_W-1:0]       pixel_offset;
  logic [drw_pkg::FULL_ADDR_W-1:0] full_address;
  logic [drw_pkg::POS_W:0]         x_stepped;
  logic [drw_pkg::ROW_W:0]         y_stepped;
  logic [drw_pkg::COL_W+2:0]       x_last_pixel;
  logic                            in_frame;

  // byte address = (y * width + x) / 8
  assign pixel_offset = drw_pkg::SUM_W'(y_position) * drw_pkg::SUM_W'(drw_pkg::PANEL_WIDTH)
                      + drw_pkg::SUM_W'(x_position);
  assign full_address = pixel_offset[drw_pkg::SUM_W-1:3];
  assign in_frame     = full_address < drw_pkg::ADDR_LIMIT;

  assign x_stepped    = {1'b0, x_position} + (drw_pkg::POS_W+1)'(8);
  assign y_stepped    = {1'b0, y_position} + (drw_pkg::ROW_W+1)'(1);
  assign x_last_pixel = {window.x_end_column, 3'b111};

  always_comb begin
    x_position_next = x_position;
    y_position_next = y_position;
    result          = '0;
    case (item.kind)
      drw_pkg::KIND_SET_X: begin
        x_position_next = {item.operand[5:0], 3'b000};
      end
      drw_pkg::KIND_SET_Y: begin
        y_position_next = item.operand;
      end
      drw_pkg::KIND_WRITE_BW, drw_pkg::KIND_WRITE_COLOUR: begin
        result.write_enable = in_frame;
        result.out_of_range = !in_frame;
        result.plane        = item.kind[0];
        result.byte_address = full_address[drw_pkg::ADDR_W-1:0];
        result.data_byte    = item.operand[drw_pkg::DATA_W-1:0];
        if (x_stepped > (drw_pkg::POS_W+1)'(x_last_pixel)) begin
          x_position_next = drw_pkg::POS_W'({window.x_start_column, 3'b000});
          if (y_stepped > (drw_pkg::ROW_W+1)'(window.y_end_row)) begin
            y_position_next = window.y_start_row;
          end else begin
            y_position_next = y_stepped[drw_pkg::ROW_W-1:0];
          end
        end else begin
          x_position_next = x_stepped[drw_pkg::POS_W-1:0];
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position <= '0;
      y_position <= '0;
    end else if (step) begin
      x_position <= x_position_next;
      y_position <= y_position_next;
    end
  end

endmodule

// ===== design/display_ram_window_writer.sv =====
// ----------------------------------------------------------------------------
// display_ram_window_writer: display RAM address counter of a panel controller
// Takes counter loads and plane byte writes, issues byte writes into the
// write window with x/y wrap and frame bound check.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid / in_stall, kind, operand): one transfer per item,
//   a counter load (x column or y row) or a data byte for the black/white or
//   colour plane. Output channel (out_valid / out_stall, write_enable, plane,
//   byte_address, data_byte, out_of_range): exactly one transfer per item, in
//   order. Counter loads give an all-zero result; a write outside the frame
//   store shows out_of_range with write_enable low.
//   Path: each item passes the input register and then the result register,
//   which drives the output channel.
//   Throughput: one item per cycle while out_stall is low; the counters update
//   in the same cycle as the address is formed, so back-to-back writes walk the window.
//   Stall: while out_stall holds a result, one more item is taken into the
//   input register; after that in_stall rises until the result is taken.
//   Reset: both counters clear to zero, the window returns to columns 0..15
//   and rows 0..295, and both pipeline registers empty.
//   Configuration: cfg_write with cfg_index/cfg_data, only while idle.
// ----------------------------------------------------------------------------
module display_ram_window_writer (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [drw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drw_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      kind,
  input  logic [drw_pkg::OPND_W-1:0]      operand,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            write_enable,
  output logic                            plane,
  output logic [drw_pkg::ADDR_W-1:0]      byte_address,
  output logic [drw_pkg::DATA_W-1:0]      data_byte,
  output logic                            out_of_range
);

  drw_pkg::window_t window;
  drw_pkg::item_t   item;
  drw_pkg::result_t result;
  drw_pkg::result_t result_q;
  logic             item_full;
  logic             in_take;
  logic             advance;

  // Configuration registers: plain writes, index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      window.x_start_column <= drw_pkg::COL_W'(0);
      window.x_end_column   <= drw_pkg::COL_W'(15);
      window.y_start_row    <= drw_pkg::ROW_W'(0);
      window.y_end_row      <= drw_pkg::ROW_W'(295);
    end else if (cfg_write) begin
      case (drw_pkg::reg_index_t'(cfg_index))
        drw_pkg::REG_X_START: window.x_start_column <= cfg_data[drw_pkg::COL_W-1:0];
        drw_pkg::REG_X_END:   window.x_end_column   <= cfg_data[drw_pkg::COL_W-1:0];
        drw_pkg::REG_Y_START: window.y_start_row    <= cfg_data[drw_pkg::ROW_W-1:0];
        drw_pkg::REG_Y_END:   window.y_end_row      <= cfg_data[drw_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result register is free or being emptied
  assign advance  = item_full && (!out_valid || !out_stall);
  // Hold off the sender only when both registers are full and the output stalls
  assign in_stall = item_full && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (in_take) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.kind    <= drw_pkg::kind_t'(kind);
      item.operand <= operand;
    end
  end

  // Counter and address logic; state steps together with the result capture
  drw_addr_counter u_counter (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .window (window),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign write_enable = result_q.write_enable;
  assign plane        = result_q.plane;
  assign byte_address = result_q.byte_address;
  assign data_byte    = result_q.data_byte;
  assign out_of_range = result_q.out_of_range;

endmodule
